// ----- rtl/core/twms_pkg.sv -----
`timescale 1ns / 1ps

package twms_pkg;

    localparam int unsigned DECAY_LOG2_Q16 = 33723;
    localparam logic [16:0] ONE_Q16        = 17'd65536;
    localparam logic [19:0] AVG_MAX        = 20'd524287;
    localparam logic [19:0] AVG_MIN_MAG    = 20'd524288;
    localparam int unsigned QUOT_BITS      = 20;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

    // 2^(-k/16) in q16
    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        logic [16:0] v;
        begin
            case (k)
                5'd0:    v = 17'd65536;
                5'd1:    v = 17'd62757;
                5'd2:    v = 17'd60097;
                5'd3:    v = 17'd57549;
                5'd4:    v = 17'd55109;
                5'd5:    v = 17'd52773;
                5'd6:    v = 17'd50535;
                5'd7:    v = 17'd48393;
                5'd8:    v = 17'd46341;
                5'd9:    v = 17'd44376;
                5'd10:   v = 17'd42495;
                5'd11:   v = 17'd40693;
                5'd12:   v = 17'd38968;
                5'd13:   v = 17'd37316;
                5'd14:   v = 17'd35734;
                5'd15:   v = 17'd34219;
                5'd16:   v = 17'd32768;
                default: v = 17'd32768;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/core/time_weighted_motion_smoother_core.sv -----
`timescale 1ns / 1ps

// channel | valid        | stall        | payload
// sample  | sample_valid | sample_stall | delta_x, delta_y, elapsed_ms
// result  | result_valid | result_stall | average_x, average_y
//
// a zero motion word is answered with the held averages in the cycle after it is taken
// any other word gets its result from a walk of the ring: one ring read per cycle
// through a 7-stage decay pipeline, then a restoring divide of 20 quotient bits, both axes in parallel
// reset clears the ring valid bits, write slot and held averages
// a word is taken only when idle and the result register is free or being taken

module time_weighted_motion_smoother_core #(
    parameter int RING_DEPTH = 32,
    parameter int TICK_MS    = 33
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [11:0] delta_x,
    input  logic signed [11:0] delta_y,
    input  logic        [9:0]  elapsed_ms,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [19:0] average_x,
    output logic signed [19:0] average_y
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = 18 + AW;
    localparam int TW = SW + 12;
    localparam int NW = SW + 20;
    localparam int Q0 = twms_pkg::DECAY_LOG2_Q16 / TICK_MS;
    localparam int R0 = twms_pkg::DECAY_LOG2_Q16 % TICK_MS;
    localparam int HALF_TICK = TICK_MS / 2;
    localparam longint MREC = ((64'd1 << 30) + TICK_MS - 1) / TICK_MS;
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(RING_DEPTH);

    twms_pkg::state_t state_reg;

    logic [33:0]         ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] ring_vld_reg;
    logic [AW-1:0]       slot_reg;
    logic [AW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       issue_cnt_reg;
    logic [6:0]          vld_reg;

    logic [33:0]         mem_q_reg;
    logic                ent_q_reg;
    logic signed [11:0]  dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic signed [11:0]  dx4_reg, dy4_reg, dx5_reg, dy5_reg;
    logic [19:0]         x1_reg;
    logic [25:0]         eq1_reg, eq2_reg, y3_reg;
    logic [50:0]         prod2_reg;
    logic [16:0]         pk4_reg;
    logic [23:0]         m4_reg;
    logic [9:0]          n4_reg;
    logic [16:0]         fac5_reg;
    logic signed [29:0]  px6_reg, py6_reg;
    logic [16:0]         w_reg;
    logic [16:0]         w_next;
    logic [SW-1:0]       sumw_reg;
    logic signed [TW-1:0] accx_reg, accy_reg;

    logic [SW-1:0]       remx_reg, remy_reg;
    logic [19:0]         numx_reg, numy_reg;
    logic                negx_reg, negy_reg;
    logic [4:0]          div_cnt_reg;

    logic signed [19:0]  avgx_reg, avgy_reg;
    logic                result_valid_reg;

    logic                accept;
    logic                nonzero;
    logic                issue;
    logic                walk_done;
    logic [33:0]         eff;
    logic [16:0]         pk, pk1, dif, frac;
    logic [TW-1:0]       magx, magy;
    logic [NW-1:0]       nx, ny;
    logic [SW:0]         tx, ty;
    logic [19:0]         resx, resy;

    assign accept       = sample_valid && !sample_stall;
    assign nonzero      = (delta_x != 12'sd0) || (delta_y != 12'sd0);
    assign sample_stall = (state_reg != twms_pkg::ST_IDLE) || (result_valid_reg && result_stall);
    assign issue        = (state_reg == twms_pkg::ST_WALK) && (issue_cnt_reg != DEPTH_CNT);
    assign walk_done    = (state_reg == twms_pkg::ST_WALK) && (issue_cnt_reg == DEPTH_CNT)
                          && (vld_reg == 7'd0);

    assign result_valid = result_valid_reg;
    assign average_x    = avgx_reg;
    assign average_y    = avgy_reg;

    always_comb
    begin
        eff    = ent_q_reg ? mem_q_reg : 34'd0;
        pk     = twms_pkg::pow2_neg({1'b0, y3_reg[15:12]});
        pk1    = twms_pkg::pow2_neg({1'b0, y3_reg[15:12]} + 5'd1);
        dif    = pk - pk1;
        frac   = pk4_reg - 17'((m4_reg + 24'd2048) >> 12);
        w_next = 17'(({17'd0, w_reg} * {17'd0, fac5_reg} + 34'd32768) >> 16);
        magx   = accx_reg[TW-1] ? TW'(-accx_reg) : TW'(accx_reg);
        magy   = accy_reg[TW-1] ? TW'(-accy_reg) : TW'(accy_reg);
        nx     = NW'({magx, 8'd0}) + NW'(sumw_reg >> 1);
        ny     = NW'({magy, 8'd0}) + NW'(sumw_reg >> 1);
        tx     = {remx_reg, numx_reg[19]};
        ty     = {remy_reg, numy_reg[19]};
        if (negx_reg)
            resx = (numx_reg > twms_pkg::AVG_MIN_MAG) ? twms_pkg::AVG_MIN_MAG
                                                      : 20'(~numx_reg + 20'd1);
        else
            resx = (numx_reg > twms_pkg::AVG_MAX) ? twms_pkg::AVG_MAX : numx_reg;
        if (negy_reg)
            resy = (numy_reg > twms_pkg::AVG_MIN_MAG) ? twms_pkg::AVG_MIN_MAG
                                                      : 20'(~numy_reg + 20'd1);
        else
            resy = (numy_reg > twms_pkg::AVG_MAX) ? twms_pkg::AVG_MAX : numy_reg;
    end

    // ring memory: write on a nonzero word, read one entry per walk cycle
    always_ff @(posedge clk)
    begin
        if (accept && nonzero)
        begin
            ring_mem[slot_reg] <= {delta_x, delta_y, elapsed_ms};
        end
        mem_q_reg <= ring_mem[rd_ptr_reg];
    end

    // decay pipeline payload
    always_ff @(posedge clk)
    begin
        dx1_reg   <= $signed(eff[33:22]);
        dy1_reg   <= $signed(eff[21:10]);
        x1_reg    <= 20'({10'd0, eff[9:0]} * 20'(R0)) + 20'(HALF_TICK);
        eq1_reg   <= 26'({16'd0, eff[9:0]} * 26'(Q0));
        dx2_reg   <= dx1_reg;
        dy2_reg   <= dy1_reg;
        prod2_reg <= 51'({31'd0, x1_reg} * 51'(MREC));
        eq2_reg   <= eq1_reg;
        dx3_reg   <= dx2_reg;
        dy3_reg   <= dy2_reg;
        y3_reg    <= eq2_reg + 26'(prod2_reg >> 30);
        dx4_reg   <= dx3_reg;
        dy4_reg   <= dy3_reg;
        pk4_reg   <= pk;
        m4_reg    <= {12'd0, dif[11:0]} * {12'd0, y3_reg[11:0]};
        n4_reg    <= y3_reg[25:16];
        dx5_reg   <= dx4_reg;
        dy5_reg   <= dy4_reg;
        fac5_reg  <= (n4_reg > 10'd16) ? 17'd0 : (frac >> n4_reg);
        px6_reg   <= 30'(dx5_reg * $signed({1'b0, w_reg}));
        py6_reg   <= 30'(dy5_reg * $signed({1'b0, w_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= twms_pkg::ST_IDLE;
            ring_vld_reg     <= '0;
            slot_reg         <= '0;
            rd_ptr_reg       <= '0;
            issue_cnt_reg    <= '0;
            vld_reg          <= '0;
            ent_q_reg        <= 1'b0;
            w_reg            <= twms_pkg::ONE_Q16;
            sumw_reg         <= '0;
            accx_reg         <= '0;
            accy_reg         <= '0;
            remx_reg         <= '0;
            remy_reg         <= '0;
            numx_reg         <= '0;
            numy_reg         <= '0;
            negx_reg         <= 1'b0;
            negy_reg         <= 1'b0;
            div_cnt_reg      <= '0;
            avgx_reg         <= '0;
            avgy_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            vld_reg   <= {vld_reg[5:0], issue};
            ent_q_reg <= ring_vld_reg[rd_ptr_reg];

            if (vld_reg[5])
            begin
                sumw_reg <= sumw_reg + SW'(w_reg);
                w_reg    <= w_next;
            end
            if (vld_reg[6])
            begin
                accx_reg <= accx_reg + TW'(px6_reg);
                accy_reg <= accy_reg + TW'(py6_reg);
            end

            case (state_reg)
                twms_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (nonzero)
                        begin
                            ring_vld_reg[slot_reg] <= 1'b1;
                            rd_ptr_reg    <= slot_reg;
                            issue_cnt_reg <= '0;
                            w_reg         <= twms_pkg::ONE_Q16;
                            sumw_reg      <= '0;
                            accx_reg      <= '0;
                            accy_reg      <= '0;
                            state_reg     <= twms_pkg::ST_WALK;
                        end
                        else
                        begin
                            result_valid_reg <= 1'b1;
                        end
                    end
                end
                twms_pkg::ST_WALK:
                begin
                    if (issue)
                    begin
                        // walk newest to oldest
                        rd_ptr_reg    <= (rd_ptr_reg == '0) ? LAST_SLOT : rd_ptr_reg - 1'b1;
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                    if (walk_done)
                    begin
                        negx_reg    <= accx_reg[TW-1];
                        negy_reg    <= accy_reg[TW-1];
                        remx_reg    <= nx[NW-1:20];
                        remy_reg    <= ny[NW-1:20];
                        numx_reg    <= nx[19:0];
                        numy_reg    <= ny[19:0];
                        div_cnt_reg <= '0;
                        state_reg   <= twms_pkg::ST_DIV;
                    end
                end
                twms_pkg::ST_DIV:
                begin
                    if (div_cnt_reg == 5'(twms_pkg::QUOT_BITS))
                    begin
                        avgx_reg         <= $signed(resx);
                        avgy_reg         <= $signed(resy);
                        result_valid_reg <= 1'b1;
                        slot_reg         <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                        state_reg        <= twms_pkg::ST_IDLE;
                    end
                    else
                    begin
                        // restoring divide, quotient bits shift into num
                        if (tx >= {1'b0, sumw_reg})
                        begin
                            remx_reg <= SW'(tx - {1'b0, sumw_reg});
                            numx_reg <= {numx_reg[18:0], 1'b1};
                        end
                        else
                        begin
                            remx_reg <= SW'(tx);
                            numx_reg <= {numx_reg[18:0], 1'b0};
                        end
                        if (ty >= {1'b0, sumw_reg})
                        begin
                            remy_reg <= SW'(ty - {1'b0, sumw_reg});
                            numy_reg <= {numy_reg[18:0], 1'b1};
                        end
                        else
                        begin
                            remy_reg <= SW'(ty);
                            numy_reg <= {numy_reg[18:0], 1'b0};
                        end
                        div_cnt_reg <= div_cnt_reg + 5'd1;
                    end
                end
                default:
                begin
                    state_reg <= twms_pkg::ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_nonzero_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && nonzero) |=> (state_reg == twms_pkg::ST_WALK))
        else $error("nonzero word did not start a ring walk");

    a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == twms_pkg::ST_WALK) |-> !result_valid_reg)
        else $error("result pending during ring walk");

    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == twms_pkg::ST_IDLE) |-> (vld_reg == 7'd0))
        else $error("decay pipeline busy while idle");
`endif

endmodule
